FILE: sv/cgr_pkg.sv
// Shared types, constants and helpers for the clipped glyph rasterizer.
// No dependencies; cgr_geom and the top level import this package.
package cgr_pkg;

    localparam int GLYPH_HEIGHT_DEF = 16;
    localparam int GLYPH_COUNT_DEF  = 128;
    localparam int GLYPH_WIDTH      = 8;
    localparam int CODE_W           = 7;
    localparam int ROWIN_W          = 4;
    localparam int REG_W            = 16;
    localparam int COORD_W          = 17;
    localparam int INK_W            = 32;
    localparam int CFG_IDX_W        = 3;
    // internal width for geometry math: coord sums plus screen size minus one
    localparam int CALC_W           = 19;

    localparam logic [REG_W-1:0] CLIP_LEFT_RST   = 16'd0;
    localparam logic [REG_W-1:0] CLIP_TOP_RST    = 16'd0;
    localparam logic [REG_W-1:0] CLIP_RIGHT_RST  = 16'd1023;
    localparam logic [REG_W-1:0] CLIP_BOTTOM_RST = 16'd767;
    localparam logic [REG_W-1:0] SHIFT_X_RST     = 16'd0;
    localparam logic [REG_W-1:0] SHIFT_Y_RST     = 16'd0;
    localparam logic [REG_W-1:0] SCREEN_W_RST    = 16'd1024;
    localparam logic [REG_W-1:0] SCREEN_H_RST    = 16'd768;

    typedef logic signed [CALC_W-1:0] t_calc;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CLIP_LEFT,
        CFG_CLIP_TOP,
        CFG_CLIP_RIGHT,
        CFG_CLIP_BOTTOM,
        CFG_SHIFT_X,
        CFG_SHIFT_Y,
        CFG_SCREEN_W,
        CFG_SCREEN_H
    } t_cfg_idx;

    typedef enum logic {
        ACT_LOAD = 1'b0,
        ACT_DRAW = 1'b1
    } t_action;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SETUP,
        ST_RUN
    } t_state;

    typedef struct packed {
        logic signed [REG_W-1:0] win_left;
        logic signed [REG_W-1:0] win_top;
        logic signed [REG_W-1:0] win_right;
        logic signed [REG_W-1:0] win_bottom;
        logic signed [REG_W-1:0] shift_x;
        logic signed [REG_W-1:0] shift_y;
        logic [REG_W-1:0]        disp_w;
        logic [REG_W-1:0]        disp_h;
    } t_cfg;

    // draw setup result handed from geometry stage to the row sequencer
    typedef struct packed {
        logic                      vld;
        logic                      hit;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic [GLYPH_WIDTH-1:0]    colmask;
    } t_job;

    function automatic t_calc sx16(input logic [REG_W-1:0] a);
        return {{(CALC_W-REG_W){a[REG_W-1]}}, a};
    endfunction

    function automatic t_calc zx16(input logic [REG_W-1:0] a);
        return {{(CALC_W-REG_W){1'b0}}, a};
    endfunction

    // font MSB is the leftmost pixel, result bit i is column i
    function automatic logic [GLYPH_WIDTH-1:0] mirror8(input logic [GLYPH_WIDTH-1:0] v);
        logic [GLYPH_WIDTH-1:0] m;
        for (int i = 0; i < GLYPH_WIDTH; i++) begin
            m[i] = v[GLYPH_WIDTH-1-i];
        end
        return m;
    endfunction

endpackage

FILE: sv/cgr_ram.sv
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module cgr_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/cgr_geom.sv
// Two-stage draw setup: translation, clip clamp, visibility test, row range, column mask.
// Depends on cgr_pkg.
module cgr_geom #(
    parameter int  GLYPH_HEIGHT = cgr_pkg::GLYPH_HEIGHT_DEF,
    localparam int RW           = $clog2(GLYPH_HEIGHT + 1)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_start,
    input  cgr_pkg::t_cfg                      i_cfg,
    input  logic signed [cgr_pkg::REG_W-1:0]   i_pos_x,
    input  logic signed [cgr_pkg::REG_W-1:0]   i_pos_y,
    output cgr_pkg::t_job                      o_job,
    output logic [RW-1:0]                      o_first_row,
    output logic [RW-1:0]                      o_end_row
);
    import cgr_pkg::*;

    localparam t_calc GH = t_calc'(GLYPH_HEIGHT);
    localparam t_calc GW = t_calc'(GLYPH_WIDTH);

    // stage 1
    logic  r_v1;
    t_calc r_x, r_y, r_cl, r_ct, r_cr, r_cb;
    t_calc n_x, n_y, n_cl, n_ct, n_cr, n_cb;
    t_calc sw_m1, sh_m1, cr_raw, cb_raw;

    // stage 2
    t_job           r_job;
    logic [RW-1:0]  r_first_row, r_end_row;
    logic           n_hit;
    logic [RW-1:0]  n_first_row, n_end_row;
    logic [GLYPH_WIDTH-1:0] n_colmask;
    t_calc d_col, e_col, d_row, e_row;
    logic [2:0] fc;
    logic [3:0] ec;

    always_comb begin
        n_x    = sx16(i_pos_x) + sx16(i_cfg.shift_x);
        n_y    = sx16(i_pos_y) + sx16(i_cfg.shift_y);
        sw_m1  = zx16(i_cfg.disp_w) - t_calc'(1);
        sh_m1  = zx16(i_cfg.disp_h) - t_calc'(1);
        cr_raw = sx16(i_cfg.win_right);
        cb_raw = sx16(i_cfg.win_bottom);
        n_cl   = i_cfg.win_left[REG_W-1] ? t_calc'(0) : sx16(i_cfg.win_left);
        n_ct   = i_cfg.win_top[REG_W-1]  ? t_calc'(0) : sx16(i_cfg.win_top);
        n_cr   = (cr_raw > sw_m1) ? sw_m1 : cr_raw;
        n_cb   = (cb_raw > sh_m1) ? sh_m1 : cb_raw;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else begin
            r_v1 <= i_start;
        end
        if (i_start) begin
            r_x  <= n_x;
            r_y  <= n_y;
            r_cl <= n_cl;
            r_ct <= n_ct;
            r_cr <= n_cr;
            r_cb <= n_cb;
        end
    end

    always_comb begin
        n_hit = !((r_cl > r_cr) || (r_ct > r_cb) ||
                  (r_x > r_cr) || (r_x + GW <= r_cl) ||
                  (r_y > r_cb) || (r_y + GH <= r_ct));

        d_col = r_cl - r_x;
        e_col = r_cr - r_x + t_calc'(1);
        d_row = r_ct - r_y;
        e_row = r_cb - r_y + t_calc'(1);

        fc = (r_x < r_cl) ? d_col[2:0] : 3'd0;
        ec = (r_x + GW > r_cr) ? e_col[3:0] : 4'(GLYPH_WIDTH);

        for (int i = 0; i < GLYPH_WIDTH; i++) begin
            n_colmask[i] = (4'(i) >= {1'b0, fc}) && (4'(i) < ec);
        end

        n_first_row = (r_y < r_ct) ? d_row[RW-1:0] : '0;
        n_end_row   = (r_y + GH > r_cb) ? e_row[RW-1:0] : RW'(GLYPH_HEIGHT);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_job.vld <= 1'b0;
        end else begin
            r_job.vld <= r_v1;
        end
        if (r_v1) begin
            r_job.hit     <= n_hit;
            r_job.x       <= r_x[COORD_W-1:0];
            r_job.y       <= r_y[COORD_W-1:0];
            r_job.colmask <= n_colmask;
            r_first_row   <= n_first_row;
            r_end_row     <= n_end_row;
        end
    end

    assign o_job       = r_job;
    assign o_first_row = r_first_row;
    assign o_end_row   = r_end_row;

endmodule

FILE: sv/clipped_glyph_rasterizer.sv
// Top level of the clipped glyph rasterizer: config registers, font RAM, row sequencer.
// Depends on cgr_pkg, cgr_ram and cgr_geom.
//
// Usage:
//   Input channel (i_in_valid/o_in_ready): a load beat (action 0) writes one font row
//   into the RAM in its accept cycle and produces nothing. A draw beat runs the
//   setup in cgr_geom (translate and clamp, then visibility and row/column range), then
//   reads one font row per cycle from the RAM, output stalls aside, over the visible rows.
//   Output channel (o_out_valid/i_out_ready): one beat per visible glyph row with a
//   nonzero mask, top to bottom; o_last_row marks the final beat of a draw. A draw with
//   nothing visible produces no beat.
//   A font row is read into the RAM read register, then moved to the held row, then to
//   the output register; a nonblank row is held until the next nonblank row or the end
//   of the range sets its last flag, so blank rows in between push it out later. One item
//   is worked on at a time, but the next item is taken while the last result still waits
//   in the output register.
//   Stalls: when the receiver holds i_out_ready low, RAM reads pause once a nonzero row
//   waits in the read data behind a held row, and the read data is held; nothing is dropped.
//   Config port (i_cfg_valid/o_cfg_ready) is always ready; write only while idle.
//   Reset: control state and config registers return to defaults; font RAM contents
//   are undefined until loaded.
module clipped_glyph_rasterizer #(
    parameter int GLYPH_HEIGHT = cgr_pkg::GLYPH_HEIGHT_DEF,
    parameter int GLYPH_COUNT  = cgr_pkg::GLYPH_COUNT_DEF
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,

    input  logic                                   i_in_valid,
    output logic                                   o_in_ready,
    input  logic                                   i_action,
    input  logic [cgr_pkg::CODE_W-1:0]             i_char_code,
    input  logic [cgr_pkg::ROWIN_W-1:0]            i_glyph_row,
    input  logic [cgr_pkg::GLYPH_WIDTH-1:0]        i_row_pattern,
    input  logic signed [cgr_pkg::REG_W-1:0]       i_pos_x,
    input  logic signed [cgr_pkg::REG_W-1:0]       i_pos_y,
    input  logic [cgr_pkg::INK_W-1:0]              i_ink,

    output logic                                   o_out_valid,
    input  logic                                   i_out_ready,
    output logic signed [cgr_pkg::COORD_W-1:0]     o_row_y,
    output logic signed [cgr_pkg::COORD_W-1:0]     o_left_x,
    output logic [cgr_pkg::GLYPH_WIDTH-1:0]        o_pixel_mask,
    output logic [cgr_pkg::INK_W-1:0]              o_pixel_color,
    output logic                                   o_last_row,

    input  logic                                   i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  logic [cgr_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [cgr_pkg::REG_W-1:0]              i_cfg_data
);
    import cgr_pkg::*;

    localparam int DEPTH = GLYPH_HEIGHT * GLYPH_COUNT;
    localparam int AW    = $clog2(DEPTH);
    localparam int RW    = $clog2(GLYPH_HEIGHT + 1);
    localparam int ROW_W = $clog2(GLYPH_HEIGHT);

    // config registers
    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.win_left   <= CLIP_LEFT_RST;
            r_cfg.win_top    <= CLIP_TOP_RST;
            r_cfg.win_right  <= CLIP_RIGHT_RST;
            r_cfg.win_bottom <= CLIP_BOTTOM_RST;
            r_cfg.shift_x    <= SHIFT_X_RST;
            r_cfg.shift_y    <= SHIFT_Y_RST;
            r_cfg.disp_w     <= SCREEN_W_RST;
            r_cfg.disp_h     <= SCREEN_H_RST;
        end else if (i_cfg_valid) begin
            unique case (t_cfg_idx'(i_cfg_index))
                CFG_CLIP_LEFT:   r_cfg.win_left   <= i_cfg_data;
                CFG_CLIP_TOP:    r_cfg.win_top    <= i_cfg_data;
                CFG_CLIP_RIGHT:  r_cfg.win_right  <= i_cfg_data;
                CFG_CLIP_BOTTOM: r_cfg.win_bottom <= i_cfg_data;
                CFG_SHIFT_X:     r_cfg.shift_x    <= i_cfg_data;
                CFG_SHIFT_Y:     r_cfg.shift_y    <= i_cfg_data;
                CFG_SCREEN_W:    r_cfg.disp_w     <= i_cfg_data;
                CFG_SCREEN_H:    r_cfg.disp_h     <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;

    // sequencer state
    t_state r_state, n_state;
    logic [CODE_W-1:0]        r_code;
    logic [INK_W-1:0]         r_ink;
    logic signed [COORD_W-1:0] r_x, r_y;
    logic [GLYPH_WIDTH-1:0]   r_colmask;
    logic [RW-1:0]            r_rd_row, r_end_row;
    logic                     r_dv;
    logic [ROW_W-1:0]         r_dv_row;
    logic                     r_hv;
    logic signed [COORD_W-1:0] r_h_row_y;
    logic [GLYPH_WIDTH-1:0]   r_h_mask;
    logic                     r_ov;
    logic signed [COORD_W-1:0] r_o_row_y, r_o_left_x;
    logic [GLYPH_WIDTH-1:0]   r_o_mask;
    logic [INK_W-1:0]         r_o_color;
    logic                     r_o_last;

    logic                     in_acc, load_we, draw_start;
    logic [AW-1:0]            waddr, raddr;
    logic [GLYPH_WIDTH-1:0]   rdata, dmask;
    logic                     dnz, out_free, consume, issue_left, rd_en;
    logic                     push_mid, push_last;

    t_job                     job;
    logic [RW-1:0]            job_first_row, job_end_row;

    cgr_geom #(
        .GLYPH_HEIGHT (GLYPH_HEIGHT)
    ) u_geom (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (draw_start),
        .i_cfg        (r_cfg),
        .i_pos_x      (i_pos_x),
        .i_pos_y      (i_pos_y),
        .o_job        (job),
        .o_first_row  (job_first_row),
        .o_end_row    (job_end_row)
    );

    // font entry = row * GLYPH_COUNT + code
    assign waddr = AW'(ROW_W'(i_glyph_row)) * AW'(GLYPH_COUNT) + AW'(i_char_code);
    assign raddr = AW'(r_rd_row[ROW_W-1:0]) * AW'(GLYPH_COUNT) + AW'(r_code);

    cgr_ram #(
        .WIDTH (GLYPH_WIDTH),
        .DEPTH (DEPTH)
    ) u_font (
        .i_clk   (i_clk),
        .i_we    (load_we),
        .i_waddr (waddr),
        .i_wdata (i_row_pattern),
        .i_re    (rd_en),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_in_ready = 1'b0;
        in_acc     = 1'b0;
        load_we    = 1'b0;
        draw_start = 1'b0;
        rd_en      = 1'b0;
        consume    = 1'b0;
        push_mid   = 1'b0;
        push_last  = 1'b0;

        dmask      = mirror8(rdata) & r_colmask;
        dnz        = |dmask;
        out_free   = !r_ov || i_out_ready;
        issue_left = r_rd_row != r_end_row;

        unique case (r_state)
            ST_IDLE: begin
                o_in_ready = 1'b1;
                in_acc     = i_in_valid;
                if (in_acc) begin
                    if (i_action == ACT_DRAW) begin
                        draw_start = 1'b1;
                        n_state    = ST_SETUP;
                    end else begin
                        // rows beyond the glyph height are ignored
                        load_we = (int'(i_glyph_row) < GLYPH_HEIGHT);
                    end
                end
            end
            ST_SETUP: begin
                if (job.vld) begin
                    n_state = job.hit ? ST_RUN : ST_IDLE;
                end
            end
            ST_RUN: begin
                // a nonzero row only moves once the held row can go out
                consume  = r_dv && (!dnz || !r_hv || out_free);
                push_mid = consume && dnz && r_hv;
                rd_en    = issue_left && (!r_dv || consume);
                if (!issue_left && !r_dv) begin
                    if (r_hv) begin
                        push_last = out_free;
                        if (out_free) begin
                            n_state = ST_IDLE;
                        end
                    end else begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dv <= 1'b0;
            r_hv <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (rd_en) begin
                r_dv <= 1'b1;
            end else if (consume) begin
                r_dv <= 1'b0;
            end

            if (consume && dnz) begin
                r_hv <= 1'b1;
            end else if (push_last) begin
                r_hv <= 1'b0;
            end

            if (push_mid || push_last) begin
                r_ov <= 1'b1;
            end else if (i_out_ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (draw_start) begin
            r_code <= i_char_code;
            r_ink  <= i_ink;
        end
        if (r_state == ST_SETUP && job.vld) begin
            r_x       <= job.x;
            r_y       <= job.y;
            r_colmask <= job.colmask;
            r_rd_row  <= job_first_row;
            r_end_row <= job_end_row;
        end else if (rd_en) begin
            r_rd_row <= r_rd_row + RW'(1);
        end
        if (rd_en) begin
            r_dv_row <= r_rd_row[ROW_W-1:0];
        end
        if (consume && dnz) begin
            r_h_row_y <= r_y + COORD_W'(r_dv_row);
            r_h_mask  <= dmask;
        end
        if (push_mid || push_last) begin
            r_o_row_y  <= r_h_row_y;
            r_o_left_x <= r_x;
            r_o_mask   <= r_h_mask;
            r_o_color  <= r_ink;
            r_o_last   <= push_last;
        end
    end

    assign o_out_valid   = r_ov;
    assign o_row_y       = r_o_row_y;
    assign o_left_x      = r_o_left_x;
    assign o_pixel_mask  = r_o_mask;
    assign o_pixel_color = r_o_color;
    assign o_last_row    = r_o_last;

endmodule
